### rtl/dmac0_pkg.sv
// Shared types and constants for the channel 0 DMA controller.
// No dependencies; imported by dmac0_core, dma_controller_channel0 and its testbench.
package dmac0_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = $clog2(NUM_CHANNELS);

    // request codes
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // bus ports
    localparam logic PORT_SELECT = 1'b0;
    localparam logic PORT_DATA   = 1'b1;

    // internal register map
    localparam logic [4:0] REG_CONTROL_BASE = 5'h10;
    localparam logic [4:0] REG_CONTROL_LAST = 5'h13;
    localparam logic [4:0] REG_PRIORITY     = 5'h14;
    localparam logic [4:0] REG_INTERRUPT    = 5'h15;
    localparam logic [4:0] REG_CHAIN        = 5'h16;

    // configuration register indexes
    localparam logic CFG_DEVICE_PRESENT = 1'b0;
    localparam logic CFG_CHAIN_SUPPORT  = 1'b1;

    // constants
    localparam logic [15:0] ADDR_RESET     = 16'hFFFF;
    localparam logic [15:0] COUNT_RESET    = 16'hFFFF;
    localparam logic [7:0]  CTRL_LOW_MASK  = 8'h0f;
    localparam logic [7:0]  CTRL_END       = 8'h80;
    localparam logic [7:0]  CTRL_BUSY      = 8'h40;
    localparam logic [7:0]  CTRL_KEEP      = 8'hc0;
    localparam logic [7:0]  PRIO_MASK      = 8'h8f;
    localparam logic [7:0]  CHAIN_END_FLAG = 8'h10;
    localparam logic [2:0]  CHAIN_MODE_ON  = 3'b001;
    localparam logic [1:0]  STALL_XFER     = 2'd3;
    localparam logic [1:0]  STALL_BURST    = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic       port_sel;
        logic [7:0] wdata;
        logic       drq;
        logic [7:0] src_byte;
    } req_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        xfer_done;
        logic        to_device;
        logic [15:0] xfer_addr;
        logic [7:0]  xfer_byte;
        logic [1:0]  stall_cycles;
        logic        irq;
        logic        busy_res;
    } rsp_t;

    typedef struct packed {
        logic device_present;
        logic chain_support;
    } cfg_t;

endpackage

### rtl/dmac0_core.sv
// Register file and per-beat update logic of the DMA controller.
// Depends on dmac0_pkg; instantiated by dma_controller_channel0.
module dmac0_core
    import dmac0_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  req_t item,
    input  cfg_t cfg,
    output rsp_t result
);

    logic [15:0] addr_reg  [NUM_CHANNELS];
    logic [15:0] count_reg [NUM_CHANNELS];
    logic [7:0]  ctrl_reg  [NUM_CHANNELS];
    logic [15:0] addr_next  [NUM_CHANNELS];
    logic [15:0] count_next [NUM_CHANNELS];
    logic [7:0]  ctrl_next  [NUM_CHANNELS];
    logic [7:0]  prio_reg, prio_next;
    logic [7:0]  intr_reg, intr_next;
    logic [7:0]  chain_reg, chain_next;
    logic [4:0]  sel_reg, sel_next;
    logic        active_reg, active_next;
    logic        burst_reg, burst_next;
    logic        irq_reg, irq_next;

    always_comb
    begin
        logic [CH_W-1:0] ch;
        logic [CH_W-1:0] cch;
        logic [15:0]     cnt_dec;
        logic            chan_ok;

        addr_next   = addr_reg;
        count_next  = count_reg;
        ctrl_next   = ctrl_reg;
        prio_next   = prio_reg;
        intr_next   = intr_reg;
        chain_next  = chain_reg;
        sel_next    = sel_reg;
        active_next = active_reg;
        burst_next  = burst_reg;
        irq_next    = irq_reg;
        result      = '0;

        ch      = sel_reg[3:2];
        cch     = sel_reg[1:0];
        cnt_dec = count_reg[0] - 16'd1;
        chan_ok = 1'b0;

        if (fire && cfg.device_present)
        begin
            case (item.req_type)
                REQ_READ:
                begin
                    if (item.port_sel == PORT_SELECT)
                    begin
                        result.rdata = {3'b000, sel_reg};
                    end
                    else if (sel_reg < REG_CONTROL_BASE)
                    begin
                        if (ch == '0 || cfg.chain_support)
                        begin
                            case (sel_reg[1:0])
                                2'd0:    result.rdata = addr_reg[ch][15:8];
                                2'd1:    result.rdata = addr_reg[ch][7:0];
                                2'd2:    result.rdata = count_reg[ch][15:8];
                                default: result.rdata = count_reg[ch][7:0];
                            endcase
                        end
                    end
                    else if (sel_reg <= REG_CONTROL_LAST)
                    begin
                        chan_ok = (cch == '0) || cfg.chain_support;
                        if (chan_ok)
                        begin
                            // reading the control register clears its end flag
                            result.rdata   = ctrl_reg[cch];
                            ctrl_next[cch] = ctrl_reg[cch] & ~CTRL_END;
                        end
                    end
                    else if (sel_reg == REG_PRIORITY)
                    begin
                        result.rdata = prio_reg;
                    end
                    else if (sel_reg == REG_INTERRUPT)
                    begin
                        result.rdata = ((chain_reg >> 4) | CTRL_END) & intr_reg;
                        chain_next   = chain_reg & CTRL_LOW_MASK;
                        intr_next    = intr_reg & ~CTRL_END;
                        irq_next     = 1'b0;
                    end
                    else if (sel_reg == REG_CHAIN)
                    begin
                        result.rdata = chain_reg & CTRL_LOW_MASK;
                    end
                end
                REQ_WRITE:
                begin
                    if (item.port_sel == PORT_SELECT)
                    begin
                        sel_next = item.wdata[4:0];
                    end
                    else if (sel_reg < REG_CONTROL_BASE)
                    begin
                        case (sel_reg[1:0])
                            2'd0:    addr_next[ch][15:8]  = item.wdata;
                            2'd1:    addr_next[ch][7:0]   = item.wdata;
                            2'd2:    count_next[ch][15:8] = item.wdata;
                            default: count_next[ch][7:0]  = item.wdata;
                        endcase
                    end
                    else if (sel_reg <= REG_CONTROL_LAST)
                    begin
                        ctrl_next[cch] = (ctrl_reg[cch] & CTRL_KEEP)
                                       | (item.wdata & CTRL_LOW_MASK);
                    end
                    else if (sel_reg == REG_PRIORITY)
                    begin
                        prio_next = item.wdata & PRIO_MASK;
                    end
                    else if (sel_reg == REG_INTERRUPT)
                    begin
                        intr_next = (intr_reg & CTRL_END) | (item.wdata & CTRL_LOW_MASK);
                    end
                    else if (sel_reg == REG_CHAIN)
                    begin
                        chain_next = (chain_reg & ~CTRL_LOW_MASK)
                                   | (item.wdata & CTRL_LOW_MASK);
                    end
                end
                REQ_START:
                begin
                    if (!active_reg && count_reg[0] != '0 && prio_reg[0])
                    begin
                        active_next  = 1'b1;
                        ctrl_next[0] = (ctrl_reg[0] & CTRL_LOW_MASK) | CTRL_BUSY;
                    end
                end
                REQ_TICK:
                begin
                    if (active_reg && prio_reg[0])
                    begin
                        if (count_reg[0] == '0)
                        begin
                            // zero count ends without a byte; burst flag is left alone
                            active_next  = 1'b0;
                            ctrl_next[0] = (ctrl_reg[0] & CTRL_LOW_MASK) | CTRL_END;
                        end
                        else
                        begin
                            if (ctrl_reg[0][1])
                            begin
                                burst_next = 1'b1;
                            end
                            if (!item.drq)
                            begin
                                if (ctrl_reg[0][1] || burst_reg)
                                begin
                                    result.stall_cycles = STALL_BURST;
                                end
                            end
                            else
                            begin
                                result.xfer_done    = 1'b1;
                                result.to_device    = ctrl_reg[0][0];
                                result.xfer_byte    = item.src_byte;
                                result.stall_cycles = STALL_XFER;
                                if (ctrl_reg[0][3])
                                begin
                                    addr_next[0] = addr_reg[0] - 16'd1;
                                end
                                else
                                begin
                                    addr_next[0] = addr_reg[0] + 16'd1;
                                end
                                count_next[0] = cnt_dec;
                                if (cnt_dec == '0)
                                begin
                                    if (cfg.chain_support
                                        && chain_reg[2:0] == CHAIN_MODE_ON)
                                    begin
                                        // reload channel 0 from channel 3
                                        addr_next[0]  = addr_reg[3];
                                        count_next[0] = count_reg[3];
                                        count_next[3] = '0;
                                    end
                                    else
                                    begin
                                        active_next  = 1'b0;
                                        burst_next   = 1'b0;
                                        ctrl_next[0] = (ctrl_reg[0] & CTRL_LOW_MASK)
                                                     | CTRL_END;
                                        chain_next   = chain_reg | CHAIN_END_FLAG;
                                        if (intr_reg[0])
                                        begin
                                            intr_next = intr_reg | CTRL_END;
                                            irq_next  = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        result.xfer_addr = result.xfer_done ? addr_reg[0] : addr_next[0];
        result.irq       = irq_next;
        result.busy_res  = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                addr_reg[i]  <= ADDR_RESET;
                count_reg[i] <= COUNT_RESET;
                ctrl_reg[i]  <= '0;
            end
            prio_reg   <= '0;
            intr_reg   <= '0;
            chain_reg  <= '0;
            sel_reg    <= '0;
            active_reg <= 1'b0;
            burst_reg  <= 1'b0;
            irq_reg    <= 1'b0;
        end
        else
        begin
            addr_reg   <= addr_next;
            count_reg  <= count_next;
            ctrl_reg   <= ctrl_next;
            prio_reg   <= prio_next;
            intr_reg   <= intr_next;
            chain_reg  <= chain_next;
            sel_reg    <= sel_next;
            active_reg <= active_next;
            burst_reg  <= burst_next;
            irq_reg    <= irq_next;
        end
    end

endmodule

### rtl/dma_controller_channel0.sv
// Top level of the channel 0 DMA controller: input register, result register, config.
// Depends on dmac0_pkg and dmac0_core.
//
// Usage:
//   Request channel: req_valid / req_stall / req (req_t). One beat is a bus read,
//   a bus write, a start request or a transfer tick.
//   Result channel: rsp_valid / rsp_stall / rsp (rsp_t). Exactly one result beat
//   per request beat, in order.
//   Config port: cfg_we / cfg_index / cfg_wdata, written by the user only while idle;
//   the block itself does not enforce this.
// Throughput: one request per clock while rsp_stall is low; the register file update
//   is a single pass of logic between the request register and the result register.
// Reset: all channel registers go to their reset values, both config bits to 1,
//   both pipeline registers empty.
// Stall: while rsp_stall holds a result, one more request is taken into the
//   request register; after that req_stall rises until the result drains.
module dma_controller_channel0
    import dmac0_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic cfg_wdata
);

    req_t in_reg;
    logic in_vld_reg, in_vld_next;
    rsp_t out_reg;
    logic out_vld_reg, out_vld_next;
    rsp_t result;
    cfg_t cfg_reg;
    logic out_ready;
    logic fire;
    logic accept;

    assign out_ready    = !out_vld_reg || !rsp_stall;
    assign fire         = in_vld_reg && out_ready;
    assign req_stall    = in_vld_reg && !out_ready;
    assign accept       = req_valid && !req_stall;
    assign in_vld_next  = accept || (in_vld_reg && !fire);
    assign out_vld_next = fire || (out_vld_reg && rsp_stall);

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    dmac0_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg             <= 1'b0;
            out_vld_reg            <= 1'b0;
            cfg_reg.device_present <= 1'b1;
            cfg_reg.chain_support  <= 1'b1;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEVICE_PRESENT: cfg_reg.device_present <= cfg_wdata;
                    CFG_CHAIN_SUPPORT:  cfg_reg.chain_support  <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= req;
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid)
        else $error("processed request produced no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (in_vld_reg && out_vld_reg))
        else $error("request stalled with room in the pipeline");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.xfer_done) |-> (!rsp.to_device && rsp.xfer_byte == 8'd0))
        else $error("transfer fields set without a transfer");

    a_xfer_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.xfer_done) |-> (rsp.stall_cycles == STALL_XFER))
        else $error("transfer beat without full stall count");
`endif

endmodule

### test/dma_controller_channel0_tb.sv
// Testbench for dma_controller_channel0: random bus, start and tick beats checked
// against a cycle-free model of the channel registers kept in a scoreboard class.
// Depends on dmac0_pkg and the RTL of dma_controller_channel0.
module dma_controller_channel0_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dmac0_pkg::*;

    // byte offsets within a channel's address/count register group
    localparam logic [1:0] OFS_ADDR_HI  = 2'd0;
    localparam logic [1:0] OFS_ADDR_LO  = 2'd1;
    localparam logic [1:0] OFS_COUNT_HI = 2'd2;
    localparam logic [1:0] OFS_COUNT_LO = 2'd3;

    class dmac_tracker;
        bit [15:0] addr [NUM_CHANNELS];
        bit [15:0] cnt [NUM_CHANNELS];
        bit [7:0]  ctrl [NUM_CHANNELS];
        bit [7:0]  prio;
        bit [7:0]  intr;
        bit [7:0]  chain;
        bit [4:0]  sel;
        bit        active;
        bit        bursting;
        bit        irq_line;
        bit        present;
        bit        chain_on;
        rsp_t      due_rsp[$];
        int        errors;
        int        results_seen;

        function new();
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                addr[i] = ADDR_RESET;
                cnt[i] = COUNT_RESET;
                ctrl[i] = 8'h00;
            end
            prio = 8'h00;
            intr = 8'h00;
            chain = 8'h00;
            sel = 5'd0;
            active = 1'b0;
            bursting = 1'b0;
            irq_line = 1'b0;
            present = 1'b1;
            chain_on = 1'b1;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_config(bit dev, bit chn);
            present = dev;
            chain_on = chn;
        endfunction

        // reads clear the end flag and the interrupt status
        function bit [7:0] read_reg(bit [4:0] r);
            bit [1:0] ch;
            bit [7:0] v;
            v = 8'h00;
            if (r < REG_CONTROL_BASE)
            begin
                ch = r[3:2];
                if (ch == 2'd0 || chain_on)
                begin
                    case (r[1:0])
                        OFS_ADDR_HI:  v = addr[ch][15:8];
                        OFS_ADDR_LO:  v = addr[ch][7:0];
                        OFS_COUNT_HI: v = cnt[ch][15:8];
                        default:      v = cnt[ch][7:0];
                    endcase
                end
            end
            else if (r <= REG_CONTROL_LAST)
            begin
                ch = r[1:0];
                if (ch == 2'd0 || chain_on)
                begin
                    v = ctrl[ch];
                    ctrl[ch] = v & ~CTRL_END;
                end
            end
            else if (r == REG_PRIORITY)
                v = prio;
            else if (r == REG_INTERRUPT)
            begin
                v = ({4'h0, chain[7:4]} | CTRL_END) & intr;
                chain = chain & CTRL_LOW_MASK;
                intr = intr & ~CTRL_END;
                irq_line = 1'b0;
            end
            else if (r == REG_CHAIN)
                v = chain & CTRL_LOW_MASK;
            return v;
        endfunction

        function void write_reg(bit [4:0] r, bit [7:0] d);
            bit [1:0] ch;
            ch = r[3:2];
            if (r < REG_CONTROL_BASE)
            begin
                case (r[1:0])
                    OFS_ADDR_HI:  addr[ch][15:8] = d;
                    OFS_ADDR_LO:  addr[ch][7:0] = d;
                    OFS_COUNT_HI: cnt[ch][15:8] = d;
                    default:      cnt[ch][7:0] = d;
                endcase
            end
            else if (r <= REG_CONTROL_LAST)
                ctrl[r[1:0]] = (ctrl[r[1:0]] & CTRL_KEEP) | (d & CTRL_LOW_MASK);
            else if (r == REG_PRIORITY)
                prio = d & PRIO_MASK;
            else if (r == REG_INTERRUPT)
                intr = (intr & CTRL_END) | (d & CTRL_LOW_MASK);
            else if (r == REG_CHAIN)
                chain = (chain & ~CTRL_LOW_MASK) | (d & CTRL_LOW_MASK);
        endfunction

        function rsp_t compute_response(req_t q);
            rsp_t e;
            bit   used_addr;
            e = '0;
            used_addr = 1'b0;
            if (present)
            begin
                case (q.req_type)
                    REQ_READ:
                        e.rdata = (q.port_sel == PORT_DATA) ? read_reg(sel) : {3'b000, sel};
                    REQ_WRITE:
                        if (q.port_sel == PORT_DATA)
                            write_reg(sel, q.wdata);
                        else
                            sel = q.wdata[4:0];
                    REQ_START:
                        if (!active && cnt[0] != 16'd0 && prio[0])
                        begin
                            active = 1'b1;
                            ctrl[0] = (ctrl[0] & CTRL_LOW_MASK) | CTRL_BUSY;
                        end
                    default:
                        if (active && prio[0])
                        begin
                            if (cnt[0] == 16'd0)
                            begin
                                // ends without a byte and without an interrupt
                                active = 1'b0;
                                ctrl[0] = (ctrl[0] & CTRL_LOW_MASK) | CTRL_END;
                            end
                            else
                            begin
                                if (ctrl[0][1])
                                    bursting = 1'b1;
                                if (!q.drq)
                                begin
                                    if (bursting)
                                        e.stall_cycles = STALL_BURST;
                                end
                                else
                                begin
                                    e.xfer_done = 1'b1;
                                    e.to_device = ctrl[0][0];
                                    e.xfer_byte = q.src_byte;
                                    e.xfer_addr = addr[0];
                                    used_addr = 1'b1;
                                    addr[0] = ctrl[0][3] ? addr[0] - 16'd1 : addr[0] + 16'd1;
                                    e.stall_cycles = STALL_XFER;
                                    cnt[0] = cnt[0] - 16'd1;
                                    if (cnt[0] == 16'd0)
                                    begin
                                        if (chain_on && chain[2:0] == CHAIN_MODE_ON)
                                        begin
                                            addr[0] = addr[3];
                                            cnt[0] = cnt[3];
                                            cnt[3] = 16'd0;
                                        end
                                        else
                                        begin
                                            active = 1'b0;
                                            bursting = 1'b0;
                                            ctrl[0] = (ctrl[0] & CTRL_LOW_MASK) | CTRL_END;
                                            chain = chain | CHAIN_END_FLAG;
                                            if (intr[0])
                                            begin
                                                intr = intr | CTRL_END;
                                                irq_line = 1'b1;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                endcase
            end
            if (!used_addr)
                e.xfer_addr = addr[0];
            e.irq = irq_line;
            e.busy_res = active;
            return e;
        endfunction

        function void note_request(req_t q);
            due_rsp.push_back(compute_response(q));
        endfunction

        task report_mismatch(string what);
            $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, what);
            errors++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            results_seen++;
            if (due_rsp.size() == 0)
            begin
                report_mismatch("result beat with no request pending");
                return;
            end
            want = due_rsp.pop_front();
            compare_field("rdata", 16'(got.rdata), 16'(want.rdata));
            compare_field("xfer_done", 16'(got.xfer_done), 16'(want.xfer_done));
            compare_field("to_device", 16'(got.to_device), 16'(want.to_device));
            compare_field("xfer_addr", got.xfer_addr, want.xfer_addr);
            compare_field("xfer_byte", 16'(got.xfer_byte), 16'(want.xfer_byte));
            compare_field("stall_cycles", 16'(got.stall_cycles), 16'(want.stall_cycles));
            compare_field("irq", 16'(got.irq), 16'(want.irq));
            compare_field("busy_res", 16'(got.busy_res), 16'(want.busy_res));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_DEVICE_PRESENT;
    logic cfg_wdata = 1'b0;

    dmac_tracker sb = new();
    int idle_pct = 38;
    int beats_sent = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;

    dma_controller_channel0 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // result side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 150;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_result(rsp);
    end

    initial
    begin
        #(2_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [4:0] chan_reg(logic [1:0] ch, logic [1:0] part);
        return {1'b0, ch, part};
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(req_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= b;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.note_request(b);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_bus(logic [1:0] kind, logic port, logic [7:0] wd);
        bit [31:0] raw;
        req_t      b;
        raw = $urandom;
        b = raw[$bits(req_t)-1:0];
        b.req_type = kind;
        b.port_sel = port;
        b.wdata = wd;
        send_beat(b);
    endtask

    task automatic send_tick(logic d, logic [7:0] src);
        bit [31:0] raw;
        req_t      b;
        raw = $urandom;
        b = raw[$bits(req_t)-1:0];
        b.req_type = REQ_TICK;
        b.drq = d;
        b.src_byte = src;
        send_beat(b);
    endtask

    task automatic send_start();
        send_bus(REQ_START, 1'($urandom), 8'($urandom));
    endtask

    task automatic bus_write(logic [4:0] r, logic [7:0] d);
        send_bus(REQ_WRITE, PORT_SELECT, {3'($urandom), r});
        send_bus(REQ_WRITE, PORT_DATA, d);
    endtask

    task automatic bus_read(logic [4:0] r);
        send_bus(REQ_WRITE, PORT_SELECT, {3'($urandom), r});
        send_bus(REQ_READ, PORT_DATA, 8'($urandom));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.due_rsp.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apply_config(logic dev, logic chn);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DEVICE_PRESENT;
        cfg_wdata <= dev;
        @(negedge clk);
        cfg_index <= CFG_CHAIN_SUPPORT;
        cfg_wdata <= chn;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_config(dev, chn);
        @(negedge clk);
    endtask

    // program channel 0 (and channel 3 when chaining), start it and tick it out
    task automatic run_channel_job();
        logic [15:0] base;
        logic [15:0] len;
        logic [15:0] alt_base;
        logic [15:0] alt_len;
        logic [7:0]  chain_bits;
        logic        chained;
        int          ticks;
        case ($urandom_range(3))
            0: base = 16'hFFFF - 16'($urandom_range(3));
            1: base = 16'($urandom_range(3));
            default: base = 16'($urandom);
        endcase
        len = 16'($urandom_range(5));
        chained = 1'($urandom);
        chain_bits = chained ? {4'($urandom), 1'b0, CHAIN_MODE_ON} : 8'($urandom);
        alt_base = 16'($urandom);
        alt_len = 16'($urandom_range(3));
        bus_write(chan_reg(2'd0, OFS_ADDR_HI), base[15:8]);
        bus_write(chan_reg(2'd0, OFS_ADDR_LO), base[7:0]);
        bus_write(chan_reg(2'd0, OFS_COUNT_HI), len[15:8]);
        bus_write(chan_reg(2'd0, OFS_COUNT_LO), len[7:0]);
        if ($urandom_range(9) < 7)
            bus_write(REG_CONTROL_BASE, 8'($urandom));
        if ($urandom_range(9) == 0)
            bus_write(REG_PRIORITY, 8'($urandom) & 8'hFE);
        else
            bus_write(REG_PRIORITY, 8'($urandom) | 8'h01);
        if ($urandom_range(9) < 7)
            bus_write(REG_INTERRUPT, 8'($urandom));
        bus_write(REG_CHAIN, chain_bits);
        if (chained)
        begin
            bus_write(chan_reg(2'd3, OFS_ADDR_HI), alt_base[15:8]);
            bus_write(chan_reg(2'd3, OFS_ADDR_LO), alt_base[7:0]);
            bus_write(chan_reg(2'd3, OFS_COUNT_HI), alt_len[15:8]);
            bus_write(chan_reg(2'd3, OFS_COUNT_LO), alt_len[7:0]);
        end
        send_start();
        ticks = int'(len) + int'(alt_len) + $urandom_range(2, 6);
        repeat (ticks)
        begin
            case ($urandom_range(29))
                0: bus_read(5'($urandom));
                1: bus_write(REG_PRIORITY, 8'($urandom));
                2: bus_write(chan_reg(2'd0, OFS_COUNT_LO), 8'h00);
                3: send_start();
                default: send_tick($urandom_range(99) < 75, 8'($urandom));
            endcase
        end
        if ($urandom_range(1))
            bus_read(REG_INTERRUPT);
        if ($urandom_range(1))
            bus_read(REG_CONTROL_BASE);
        if ($urandom_range(1))
            bus_read(5'($urandom));
    endtask

    task automatic run_random(int count);
        int target;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            if ($urandom_range(99) < 75)
                run_channel_job();
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_bus(2'($urandom), 1'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        apply_config(1'b1, 1'b1);

        // directed beats
        send_bus(REQ_READ, PORT_SELECT, 8'h00);
        send_bus(REQ_READ, PORT_DATA, 8'hFF);
        send_tick(1'b1, 8'hFF);                  // idle channel ignores the tick
        send_start();                            // refused: request enable clear
        send_bus(REQ_WRITE, PORT_SELECT, 8'hFF); // undecoded register
        send_bus(REQ_WRITE, PORT_DATA, 8'hFF);
        send_bus(REQ_READ, PORT_DATA, 8'h00);
        bus_write(REG_PRIORITY, 8'hFF);
        bus_write(chan_reg(2'd0, OFS_COUNT_HI), 8'h00);
        bus_write(chan_reg(2'd0, OFS_COUNT_LO), 8'h01);
        bus_write(REG_CONTROL_BASE, 8'h07);      // to device, burst, count up
        bus_write(REG_INTERRUPT, 8'h01);
        send_start();
        send_start();                            // refused while active
        send_tick(1'b0, 8'h00);                  // burst stall without DRQ
        send_tick(1'b1, 8'hFF);                  // last byte at 0xFFFF, address wraps
        bus_read(REG_INTERRUPT);

        run_random(30);
        hold_req = 1'b1;                         // result side backs up, input fills
        run_random(190);
        wait_drained();

        apply_config(1'b1, 1'b0);
        run_random(80);
        wait_drained();

        apply_config(1'b0, 1'b1);
        run_random(30);
        wait_drained();

        apply_config(1'b0, 1'b0);
        run_random(15);
        wait_drained();

        apply_config(1'b1, 1'b1);
        idle_pct = 0;
        run_random(60);
        wait_drained();

        repeat (5) @(negedge clk);
        if (sb.errors == 0 && sb.due_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
